// ===== sv/radiotap_dot11_frame_stripper_defines.svh =====
`ifndef RADIOTAP_DOT11_FRAME_STRIPPER_DEFINES_SVH
`define RADIOTAP_DOT11_FRAME_STRIPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define RTSTRIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define RTSTRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rtstrip_pkg.sv =====
`timescale 1ns / 1ps

package rtstrip_pkg;

	localparam logic [1:0] KIND_BODY   = 2'd0;
	localparam logic [1:0] KIND_EMPTY  = 2'd1;
	localparam logic [1:0] KIND_BAD    = 2'd2;
	localparam logic [1:0] KIND_ENDED  = 2'd3;

	localparam logic [7:0]  QOS_FC     = 8'h88;
	localparam logic [16:0] HDR_QOS    = 17'd26;
	localparam logic [16:0] HDR_PLAIN  = 17'd24;
	localparam logic [16:0] SEQ_OFFSET = 17'd22;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  body_byte;
		logic [11:0] sequence_number;
		logic        last_of_frame;
	} rtstrip_res_t;

endpackage

// ===== sv/rtstrip_parser.sv =====
`timescale 1ns / 1ps

module rtstrip_parser import rtstrip_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [7:0]   in_byte,
	output logic         res_valid,
	output rtstrip_res_t res
);

	localparam logic [1:0] PH_PREFIX = 2'd0;
	localparam logic [1:0] PH_FRAME  = 2'd1;
	localparam logic [1:0] PH_ENDED  = 2'd2;

	logic [1:0]  phase_q;
	logic [1:0]  pcnt_q;
	logic [31:0] len_q;
	logic [31:0] pos_q;
	logic [31:0] ffb_q;
	logic [15:0] rl_q;
	logic        qos_q;
	logic [7:0]  seqlo_q;
	logic [11:0] seq_q;

	logic [31:0] full_len;
	logic        final_b;
	logic        p_lt4;
	logic [31:0] ffb_ins;
	logic [15:0] rl_new;
	logic [7:0]  fc_kept;
	logic        rl_hit;
	logic        qos_now;
	logic [16:0] hend;
	logic [16:0] seq_pos;
	logic        seq_lo_hit;
	logic        seq_hi_hit;
	logic [11:0] seq_next;
	logic        over;
	logic        body;

	assign full_len = {in_byte, len_q[23:0]};
	assign final_b  = ((pos_q + 32'd1) == len_q);
	assign p_lt4    = (pos_q[31:2] == 30'd0);

	always_comb begin
		ffb_ins = ffb_q;
		case (pos_q[1:0])
			2'd0:    ffb_ins[7:0]   = in_byte;
			2'd1:    ffb_ins[15:8]  = in_byte;
			2'd2:    ffb_ins[23:16] = in_byte;
			default: ffb_ins[31:24] = in_byte;
		endcase
	end

	// radiotap length is complete once frame byte 3 is in
	assign rl_new = {in_byte, ffb_q[23:16]};

	always_comb begin
		case (rl_new[1:0])
			2'd0:    fc_kept = ffb_q[7:0];
			2'd1:    fc_kept = ffb_q[15:8];
			2'd2:    fc_kept = ffb_q[23:16];
			default: fc_kept = in_byte;
		endcase
	end

	assign rl_hit     = (pos_q == {16'd0, rl_q});
	assign qos_now    = rl_hit ? (in_byte == QOS_FC) : qos_q;
	assign hend       = {1'b0, rl_q} + (qos_now ? HDR_QOS : HDR_PLAIN);
	assign seq_pos    = {1'b0, rl_q} + SEQ_OFFSET;
	assign seq_lo_hit = (pos_q == {15'd0, seq_pos});
	assign seq_hi_hit = (pos_q == ({15'd0, seq_pos} + 32'd1));
	assign seq_next   = seq_hi_hit ? {in_byte, seqlo_q[7:4]} : seq_q;
	assign over       = ({15'd0, hend} > len_q);
	assign body       = !p_lt4 && (pos_q >= {15'd0, hend}) && !over;

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (in_valid) begin
			case (phase_q)
				PH_PREFIX: begin
					if (pcnt_q == 2'd3 && full_len == 32'd0) begin
						res_valid         = 1'b1;
						res.kind          = KIND_ENDED;
						res.last_of_frame = 1'b1;
					end
				end
				PH_FRAME: begin
					if (p_lt4) begin
						// record ends inside the first four bytes: always malformed
						if (final_b) begin
							res_valid         = 1'b1;
							res.kind          = KIND_BAD;
							res.last_of_frame = 1'b1;
						end
					end else if (body) begin
						res_valid           = 1'b1;
						res.kind            = KIND_BODY;
						res.body_byte       = in_byte;
						res.sequence_number = seq_next;
						res.last_of_frame   = final_b;
					end else if (final_b) begin
						res_valid         = 1'b1;
						res.last_of_frame = 1'b1;
						if (over) begin
							res.kind = KIND_BAD;
						end else begin
							res.kind            = KIND_EMPTY;
							res.sequence_number = seq_next;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pcnt_q  <= 2'd0;
			len_q   <= '0;
			pos_q   <= '0;
			ffb_q   <= '0;
			rl_q    <= '0;
			qos_q   <= 1'b0;
			seqlo_q <= '0;
			seq_q   <= '0;
		end else if (in_valid) begin
			case (phase_q)
				PH_PREFIX: begin
					case (pcnt_q)
						2'd0:    len_q        <= {24'd0, in_byte};
						2'd1:    len_q[15:8]  <= in_byte;
						2'd2:    len_q[23:16] <= in_byte;
						default: len_q[31:24] <= in_byte;
					endcase
					pcnt_q <= pcnt_q + 2'd1;
					if (pcnt_q == 2'd3) begin
						if (full_len == 32'd0) begin
							phase_q <= PH_ENDED;
						end else begin
							phase_q <= PH_FRAME;
							pos_q   <= '0;
							ffb_q   <= '0;
							rl_q    <= '0;
							qos_q   <= 1'b0;
							seqlo_q <= '0;
							seq_q   <= '0;
						end
					end
				end
				PH_FRAME: begin
					pos_q <= pos_q + 32'd1;
					if (p_lt4) begin
						ffb_q <= ffb_ins;
						if (pos_q[1:0] == 2'd3) begin
							rl_q <= rl_new;
							if (rl_new[15:2] == 14'd0)
								qos_q <= (fc_kept == QOS_FC);
						end
					end else begin
						qos_q <= qos_now;
						if (seq_lo_hit)
							seqlo_q <= in_byte;
						seq_q <= seq_next;
					end
					if (final_b) begin
						phase_q <= PH_PREFIX;
						pcnt_q  <= 2'd0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/radiotap_dot11_frame_stripper.sv =====
`timescale 1ns / 1ps
// Radiotap / 802.11 header stripper for a length-prefixed capture byte stream.
// s_axis: one stream byte per beat. Records are a 4-byte little-endian length
//   followed by the captured frame (radiotap header, 802.11 header, body).
// m_axis: at most one result beat per input beat. tuser holds the kind
//   (body byte, empty-body frame, malformed frame, end of stream), tdata the
//   body byte and the 802.11 sequence number, tlast marks a frame's final beat.
// Throughput: one byte per cycle while s_axis_tready is high; the whole parse of a
//   byte is combinational logic from the input beat into the output stage.
// A result is registered in the output register (the skid register while m_axis stalls).
// A zero-length record gives one end-of-stream beat; afterwards every input
//   beat is taken and dropped.
// Stall: a two-entry output stage (output register plus skid register) keeps
//   s_axis_tready registered; it drops only while both entries are full.
// Reset: arst_n clears the parser to expect a length prefix and empties the
//   output stage.
`include "radiotap_dot11_frame_stripper_defines.svh"

module radiotap_dot11_frame_stripper import rtstrip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] body_byte, [19:8] sequence_number, zero pad
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last_of_frame
);

	logic         in_acc;
	logic         res_valid;
	rtstrip_res_t res;
	logic         out_valid_q;
	rtstrip_res_t out_q;
	logic         skid_valid_q;
	rtstrip_res_t skid_q;
	logic         out_free;

	assign s_axis_tready = !skid_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	rtstrip_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_acc),
		.in_byte   (s_axis_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.sequence_number, out_q.body_byte};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last_of_frame;

	`RTSTRIP_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`RTSTRIP_ASSERT_NEXT(a_skid_kept, skid_valid_q && !m_axis_tready, skid_valid_q, "skid beat lost during stall")
	`RTSTRIP_ASSERT_NOW(a_end_is_last, m_axis_tvalid && (m_axis_tuser == KIND_ENDED || m_axis_tuser == KIND_BAD), m_axis_tlast && (m_axis_tdata == 24'd0), "end or malformed beat not final or not clear")

endmodule
